// ----- rtl/core/lcdnw_pkg.sv -----
// Shared types, codes and the init command table for the LCD nibble write sequencer.
package lcdnw_pkg;

	// request codes
	localparam logic [2:0] OP_INIT  = 3'd0;
	localparam logic [2:0] OP_CMD   = 3'd1;
	localparam logic [2:0] OP_DATA  = 3'd2;
	localparam logic [2:0] OP_GOTO  = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_PIN      = 2'd0;
	localparam logic [1:0] STAT_REFUSED  = 2'd1;
	localparam logic [1:0] STAT_INIT_DONE = 2'd2;

	// queue entry kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_INIT   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [7:0] GOTO_BASE  = 8'h80;
	localparam logic [7:0] ROW_STRIDE = 8'h40;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;

	localparam int FIXED_INIT_LEN = 5;
	localparam int IDX_W          = $clog2(FIXED_INIT_LEN);

	// six pin events per byte
	localparam logic [2:0] STEP_LAST = 3'd5;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] byte_value;
		logic       row;
		logic [5:0] column;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_write;
		logic       enable;
		logic [3:0] data_nibble;
		logic [1:0] status;
		logic       last;
	} ev_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       rs;
		logic [7:0] byte_val;
		logic [1:0] status;
	} entry_t;

	function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			IDX_W'(0): b = 8'h02;  // cursor home
			IDX_W'(1): b = 8'h28;  // 4-bit, 2 lines
			IDX_W'(2): b = 8'h0E;  // display on, cursor on
			IDX_W'(3): b = 8'h06;  // entry mode increment
			IDX_W'(4): b = 8'h01;  // clear
			default:   b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/core/lcdnw_front.sv -----
// Request classifier: tracks the initialised flag and turns requests into queue entries.
module lcdnw_front import lcdnw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_ready,
	input  req_t   req,
	output logic   push,
	output entry_t push_entry,
	input  logic   q_ready
);

	logic init_f_q;
	logic accept;
	logic keep;

	assign req_ready = q_ready;
	assign accept    = req_valid && req_ready;
	assign push      = accept && keep;

	always_comb begin
		keep       = 1'b1;
		push_entry = '{kind: KIND_BYTE, rs: 1'b0, byte_val: req.byte_value, status: STAT_PIN};
		unique case (req.operation)
			OP_INIT: begin
				if (init_f_q) begin
					push_entry.kind   = KIND_STATUS;
					push_entry.status = STAT_INIT_DONE;
				end else begin
					push_entry.kind = KIND_INIT;
				end
			end
			OP_CMD: begin
			end
			OP_DATA: begin
				push_entry.rs = 1'b1;
				if (!init_f_q) begin
					push_entry.kind   = KIND_STATUS;
					push_entry.status = STAT_REFUSED;
				end
			end
			OP_GOTO: begin
				push_entry.byte_val = GOTO_BASE | (8'(req.column) + (req.row ? ROW_STRIDE : 8'h00));
				if (!init_f_q) begin
					push_entry.kind   = KIND_STATUS;
					push_entry.status = STAT_REFUSED;
				end
			end
			OP_CLEAR: begin
				push_entry.byte_val = CMD_CLEAR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_f_q <= 1'b0;
		end else if (accept && req.operation == OP_INIT) begin
			init_f_q <= 1'b1;
		end
	end

	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		init_f_q |=> init_f_q)
		else $error("initialised flag dropped");

endmodule

// ----- rtl/core/lcdnw_queue.sv -----
// Two-entry queue between the classifier and the pin sequencer.
module lcdnw_queue import lcdnw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   q_ready,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t     mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready    = count_q != 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_ready)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ----- rtl/core/lcdnw_back.sv -----
// Pin sequencer: plays queue entries out as pin events through an output register.
module lcdnw_back import lcdnw_pkg::*; #(
	parameter int INIT_LEN = 5
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  entry_t head,
	output logic   pop,
	output logic   ev_valid,
	input  logic   ev_ready,
	output ev_t    ev
);

	logic [2:0]       step_q;
	logic [IDX_W-1:0] idx_q;
	logic             pin_rs_q;
	logic             pin_en_q;
	logic [3:0]       pin_data_q;
	logic             out_valid_q;
	ev_t              out_q;

	logic       adv;
	logic       final_step;
	logic       done;
	logic [7:0] cur_byte;
	logic [3:0] nib;
	logic       nx_en;
	logic [3:0] nx_data;

	assign adv        = head_valid && (!out_valid_q || ev_ready);
	assign final_step = step_q == STEP_LAST;
	assign done       = (head.kind == KIND_STATUS) ||
	                    (final_step && (head.kind != KIND_INIT ||
	                                    idx_q == IDX_W'(INIT_LEN - 1)));
	assign pop        = adv && done;
	assign cur_byte   = (head.kind == KIND_INIT) ? init_byte(idx_q) : head.byte_val;
	assign nib        = (step_q < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];

	always_comb begin
		nx_en   = 1'b0;
		nx_data = pin_data_q;
		case (step_q) inside
			3'd0, 3'd3: nx_data = nib;
			3'd1, 3'd4: nx_en   = 1'b1;
			default:    nx_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			idx_q       <= '0;
			pin_rs_q    <= 1'b0;
			pin_en_q    <= 1'b0;
			pin_data_q  <= 4'h0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (ev_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && head.kind != KIND_STATUS) begin
				pin_rs_q   <= head.rs;
				pin_en_q   <= nx_en;
				pin_data_q <= nx_data;
				step_q     <= final_step ? 3'd0 : step_q + 3'd1;
				if (final_step) begin
					idx_q <= done ? '0 : idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.read_write <= 1'b0;
			out_q.last       <= done;
			if (head.kind == KIND_STATUS) begin
				out_q.reg_select  <= pin_rs_q;
				out_q.enable      <= pin_en_q;
				out_q.data_nibble <= pin_data_q;
				out_q.status      <= head.status;
			end else begin
				out_q.reg_select  <= head.rs;
				out_q.enable      <= nx_en;
				out_q.data_nibble <= nx_data;
				out_q.status      <= STAT_PIN;
			end
		end
	end

	assign ev_valid = out_valid_q;
	assign ev       = out_q;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != STAT_PIN |-> out_q.last)
		else $error("status result not marked last");

	a_en_low_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> !out_q.enable)
		else $error("request ended with EN high");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("pin step out of range");

endmodule

// ----- rtl/core/char_lcd_nibble_write_sequencer.sv -----
// Top level of the character LCD 4-bit write sequencer.
// Each accepted request becomes a stream of pin events for a character LCD on a
// 4-bit bus, one result transfer per event; the block keeps RS, EN and D7..D4 as
// they stand after the last event. A byte goes out as six events (high nibble
// placed, EN up, EN down, then the low nibble the same way), so a raw command,
// data, goto or clear request takes six events, init takes six per
// command (INIT_COMMANDS, taken between one and five, so thirty by default), a
// refused or repeated-init request takes one, and operations five to seven give
// nothing. The output side sets the rate: the sequencer issues at most one
// event per cycle into its output register, while the classifier keeps taking
// requests into a two-entry queue, so req_ready drops only when that queue is full.
module char_lcd_nibble_write_sequencer import lcdnw_pkg::*; #(
	parameter int INIT_COMMANDS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic ev_valid,
	input  logic ev_ready,
	output ev_t  ev
);

	// commands actually sent by init: at least one, at most the table length
	localparam int INIT_LEN = (INIT_COMMANDS < 1) ? 1 :
	                          (INIT_COMMANDS > FIXED_INIT_LEN) ? FIXED_INIT_LEN :
	                          INIT_COMMANDS;

	logic   push;
	entry_t push_entry;
	logic   q_ready;
	logic   pop;
	logic   head_valid;
	entry_t head;

	// front: classify, refuse or drop; owns the initialised flag
	lcdnw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	// decoupling queue
	lcdnw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: nibble/strobe sequencing, pin state, output register
	lcdnw_back #(
		.INIT_LEN (INIT_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ev_valid   (ev_valid),
		.ev_ready   (ev_ready),
		.ev         (ev)
	);

endmodule
